FILE: sv/sapt_pkg.sv
// Shared types and constants for the segment and page address translator.
// No dependencies; the controller, datapath and top level import this package.
package sapt_pkg;

    // Command codes carried by the command field of an input word.
    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_WR_DESC   = 2'd1,
        CMD_WR_DIR    = 2'd2,
        CMD_WR_TABLE  = 2'd3
    } cmd_t;

    // Translation mode register codes; the unused code acts as paged mode.
    typedef enum logic [1:0] {
        MODE_REAL  = 2'd0,
        MODE_FLAT  = 2'd1,
        MODE_PAGED = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    // Fault codes reported with each result word.
    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_SEL   = 2'd1,
        FAULT_DIR   = 2'd2,
        FAULT_TABLE = 2'd3
    } fault_t;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam int unsigned FRAME_W  = 20;
    localparam int unsigned ENTRY_W  = FRAME_W + 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // zero the stores at the sweep counter
        logic load;      // capture an accepted input word
        logic write;     // perform the latched store write
        logic hold_lin;  // keep the linear address for the page stage
        logic fin_exec;  // finish in the first stage
        logic fin_desc;  // finish after the descriptor lookup
        logic fin_page;  // finish after the page lookup
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_write;
        logic mode_real;
        logic mode_flat;
        logic desc_oob;
        logic dir_oob;
    } dp_status_t;

endpackage

FILE: sv/sapt_ram.sv
// Generic single-port RAM with a registered read, used for every store.
// No dependencies.
module sapt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read at the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/sapt_ctrl.sv
// Controller state machine for the address translator.
// Depends on sapt_pkg for the command and status structs.
module sapt_ctrl import sapt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_DESC  = 5'b01000,
        S_PAGE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the store clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_write)
                begin
                    cmd.write    = 1'b1;
                    cmd.fin_exec = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (status.mode_real || status.desc_oob)
                begin
                    cmd.fin_exec = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_DESC;
                end
            end
            S_DESC:
            begin
                cmd.hold_lin = 1'b1;
                if (status.mode_flat || status.dir_oob)
                begin
                    cmd.fin_desc = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_PAGE;
                end
            end
            S_PAGE:
            begin
                cmd.fin_page = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTH
    // An accepted word always moves the machine into the first work stage.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && start |=> (state_reg == S_EXEC))
        else $error("accepted word did not reach the first stage");

    // The page stage is only entered from the descriptor stage.
    a_page_after_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAGE) |-> ($past(state_reg) == S_DESC))
        else $error("page stage entered out of order");

    // Exactly one finish command at most in any cycle.
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fin_exec, cmd.fin_desc, cmd.fin_page}))
        else $error("more than one finish command");
`endif

endmodule

FILE: sv/sapt_datapath.sv
// Datapath of the address translator: input latches, the three stores,
// the linear address adder and the result register.
// Depends on sapt_pkg and sapt_ram.
module sapt_datapath import sapt_pkg::*; #(
    parameter int DESC_ENTRIES = 16,
    parameter int BACKED_DIRS  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic        translate_mode_we,
    input  logic [1:0]  translate_mode,
    input  logic [1:0]  command,
    input  logic [15:0] selector,
    input  logic [31:0] offset,
    input  logic [9:0]  write_dir_index,
    input  logic [9:0]  write_table_index,
    input  logic        write_present,
    input  logic [31:0] write_value,
    output logic        done,
    output logic [31:0] phys_addr,
    output logic [31:0] lin_addr,
    output logic [1:0]  fault_kind
);

    localparam int DAW       = (DESC_ENTRIES > 1) ? $clog2(DESC_ENTRIES) : 1;
    localparam int DIRW      = (BACKED_DIRS > 1) ? $clog2(BACKED_DIRS) : 1;
    localparam int TDEPTH    = BACKED_DIRS * 1024;
    localparam int TAW       = $clog2(TDEPTH);
    localparam int CLR_DEPTH = (DESC_ENTRIES > TDEPTH) ? DESC_ENTRIES : TDEPTH;
    localparam int CW        = $clog2(CLR_DEPTH);

    // Latched input word.
    cmd_t        cmd_reg;
    logic [15:0] sel_reg;
    logic [31:0] off_reg;
    logic [9:0]  wdir_reg;
    logic [9:0]  wtab_reg;
    logic        wpres_reg;
    logic [31:0] wval_reg;

    // Control registers.
    mode_t       mode_reg;
    logic [CW-1:0] clr_cnt_reg;
    logic [31:0] lin_hold_reg;

    // Result register.
    logic        done_reg;
    logic [31:0] phys_reg;
    logic [31:0] lin_out_reg;
    fault_t      fault_reg;

    // Store ports.
    logic             desc_we;
    logic [DAW-1:0]   desc_addr;
    logic [31:0]      desc_wdata;
    logic [31:0]      desc_rdata;
    logic             dir_we;
    logic [DIRW-1:0]  dir_addr;
    logic             dir_wdata;
    logic             dir_rdata;
    logic             tab_we;
    logic [TAW-1:0]   tab_addr;
    logic [ENTRY_W-1:0] tab_wdata;
    logic [ENTRY_W-1:0] tab_rdata;

    // Address arithmetic.
    logic [12:0] desc_idx;
    logic [12:0] wdesc_idx;
    logic [31:0] real_addr;
    logic [31:0] linear;
    logic [9:0]  lin_dir;
    logic [9:0]  lin_tab;
    logic [19:0] wtab_full;
    logic [19:0] rtab_full;
    logic        is_write;

    // Mode register, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PAGED;
        end
        else if (translate_mode_we)
        begin
            mode_reg <= mode_t'(translate_mode);
        end
    end

    // Clearing sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
        end
    end

    // Input word capture and linear address hold.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= cmd_t'(command);
            sel_reg   <= selector;
            off_reg   <= offset;
            wdir_reg  <= write_dir_index;
            wtab_reg  <= write_table_index;
            wpres_reg <= write_present;
            wval_reg  <= write_value;
        end
        if (cmd.hold_lin)
        begin
            lin_hold_reg <= linear;
        end
    end

    // Address arithmetic for all three modes.
    assign is_write  = (cmd_reg != CMD_TRANSLATE);
    assign desc_idx  = sel_reg[15:3];
    assign wdesc_idx = {3'b000, wdir_reg};
    assign real_addr = {12'h000, sel_reg, 4'h0} + {16'h0000, off_reg[15:0]};
    assign linear    = desc_rdata + off_reg;
    assign lin_dir   = linear[31:22];
    assign lin_tab   = linear[21:12];
    assign wtab_full = {wdir_reg, wtab_reg};
    assign rtab_full = {lin_dir, lin_tab};

    // Status back to the controller.
    assign status.clear_last = (32'(clr_cnt_reg) == 32'(CLR_DEPTH - 1));
    assign status.is_write   = is_write;
    assign status.mode_real  = (mode_reg == MODE_REAL);
    assign status.mode_flat  = (mode_reg == MODE_FLAT);
    assign status.desc_oob   = (32'(desc_idx) >= 32'(DESC_ENTRIES));
    assign status.dir_oob    = (32'(lin_dir) >= 32'(BACKED_DIRS));

    // Store port selection: clearing sweep, latched write, or lookup.
    always_comb
    begin
        desc_we    = 1'b0;
        dir_we     = 1'b0;
        tab_we     = 1'b0;
        desc_addr  = desc_idx[DAW-1:0];
        dir_addr   = lin_dir[DIRW-1:0];
        tab_addr   = rtab_full[TAW-1:0];
        desc_wdata = wval_reg;
        dir_wdata  = wpres_reg;
        tab_wdata  = {wval_reg[FRAME_W-1:0], wpres_reg};
        if (cmd.clear)
        begin
            desc_addr  = clr_cnt_reg[DAW-1:0];
            dir_addr   = clr_cnt_reg[DIRW-1:0];
            tab_addr   = clr_cnt_reg[TAW-1:0];
            desc_wdata = '0;
            dir_wdata  = 1'b0;
            tab_wdata  = '0;
            desc_we    = (32'(clr_cnt_reg) < 32'(DESC_ENTRIES));
            dir_we     = (32'(clr_cnt_reg) < 32'(BACKED_DIRS));
            tab_we     = (32'(clr_cnt_reg) < 32'(TDEPTH));
        end
        else if (cmd.write)
        begin
            desc_addr = wdesc_idx[DAW-1:0];
            dir_addr  = wdir_reg[DIRW-1:0];
            tab_addr  = wtab_full[TAW-1:0];
            desc_we   = (cmd_reg == CMD_WR_DESC) &&
                        (32'(wdir_reg) < 32'(DESC_ENTRIES));
            dir_we    = (cmd_reg == CMD_WR_DIR) &&
                        (32'(wdir_reg) < 32'(BACKED_DIRS));
            tab_we    = (cmd_reg == CMD_WR_TABLE) &&
                        (32'(wdir_reg) < 32'(BACKED_DIRS));
        end
    end

    sapt_ram #(
        .WIDTH (32),
        .DEPTH (DESC_ENTRIES)
    ) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .addr  (desc_addr),
        .wdata (desc_wdata),
        .rdata (desc_rdata)
    );

    sapt_ram #(
        .WIDTH (1),
        .DEPTH (BACKED_DIRS)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .addr  (dir_addr),
        .wdata (dir_wdata),
        .rdata (dir_rdata)
    );

    sapt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TDEPTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (tab_we),
        .addr  (tab_addr),
        .wdata (tab_wdata),
        .rdata (tab_rdata)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin_exec || cmd.fin_desc || cmd.fin_page;
        end
    end

    // Result word for whichever stage finishes.
    always_ff @(posedge clk)
    begin
        if (cmd.fin_exec)
        begin
            if (is_write)
            begin
                phys_reg    <= '0;
                lin_out_reg <= '0;
                fault_reg   <= FAULT_NONE;
            end
            else if (mode_reg == MODE_REAL)
            begin
                phys_reg    <= real_addr;
                lin_out_reg <= real_addr;
                fault_reg   <= FAULT_NONE;
            end
            else
            begin
                phys_reg    <= ALL_ONES;
                lin_out_reg <= '0;
                fault_reg   <= FAULT_SEL;
            end
        end
        else if (cmd.fin_desc)
        begin
            lin_out_reg <= linear;
            if (mode_reg == MODE_FLAT)
            begin
                phys_reg  <= linear;
                fault_reg <= FAULT_NONE;
            end
            else
            begin
                phys_reg  <= ALL_ONES;
                fault_reg <= FAULT_DIR;
            end
        end
        else if (cmd.fin_page)
        begin
            lin_out_reg <= lin_hold_reg;
            if (!dir_rdata)
            begin
                phys_reg  <= ALL_ONES;
                fault_reg <= FAULT_DIR;
            end
            else if (!tab_rdata[0])
            begin
                phys_reg  <= ALL_ONES;
                fault_reg <= FAULT_TABLE;
            end
            else
            begin
                phys_reg  <= {tab_rdata[ENTRY_W-1:1], lin_hold_reg[11:0]};
                fault_reg <= FAULT_NONE;
            end
        end
    end

    assign done       = done_reg;
    assign phys_addr  = phys_reg;
    assign lin_addr   = lin_out_reg;
    assign fault_kind = fault_reg;

endmodule

FILE: sv/segment_and_page_address_translator.sv
// Top level of the segment and page address translator.
// Depends on sapt_pkg, sapt_ctrl, sapt_datapath and sapt_ram.
//
//  Channel   Handshake               Ports
//  --------  ----------------------  ---------------------------------------
//  input     start && !busy          command, selector, offset,
//                                    write_dir_index, write_table_index,
//                                    write_present, write_value
//  result    done (one-cycle strobe) phys_addr, lin_addr, fault_kind
//  config    translate_mode_we       translate_mode
//
// Write commands, real mode and selector faults finish in the first work
// stage; protected mode without paging and out-of-range directories finish
// after the descriptor read; a full paged lookup finishes after the
// descriptor read followed by the directory and table reads in synchronous
// RAM. The next word is accepted in the cycle that done is shown. After
// reset busy stays high while the stores are cleared one entry per cycle.
// The receiver cannot stall results.
module segment_and_page_address_translator import sapt_pkg::*; #(
    parameter int DESC_ENTRIES = 16,
    parameter int BACKED_DIRS  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] selector,
    input  logic [31:0] offset,
    input  logic [9:0]  write_dir_index,
    input  logic [9:0]  write_table_index,
    input  logic        write_present,
    input  logic [31:0] write_value,
    output logic        done,
    output logic [31:0] phys_addr,
    output logic [31:0] lin_addr,
    output logic [1:0]  fault_kind,
    input  logic        translate_mode_we,
    input  logic [1:0]  translate_mode
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // Sequencer.
    sapt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (ctrl_cmd),
        .busy   (busy)
    );

    // Stores, adders and result register.
    sapt_datapath #(
        .DESC_ENTRIES (DESC_ENTRIES),
        .BACKED_DIRS  (BACKED_DIRS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (ctrl_cmd),
        .status            (dp_status),
        .translate_mode_we (translate_mode_we),
        .translate_mode    (translate_mode),
        .command           (command),
        .selector          (selector),
        .offset            (offset),
        .write_dir_index   (write_dir_index),
        .write_table_index (write_table_index),
        .write_present     (write_present),
        .write_value       (write_value),
        .done              (done),
        .phys_addr         (phys_addr),
        .lin_addr          (lin_addr),
        .fault_kind        (fault_kind)
    );

`ifndef SYNTH
    // A result word is only shown once the block is ready for the next word.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted word did not occupy the block");

    // Every fault reports an all-ones physical address.
    a_fault_ones: assert property (@(posedge clk) disable iff (!rst_n)
        done && (fault_kind != FAULT_NONE) |-> (phys_addr == ALL_ONES))
        else $error("fault without all-ones address");

    // A selector fault reports a zero linear address.
    a_sel_fault_lin: assert property (@(posedge clk) disable iff (!rst_n)
        done && (fault_kind == FAULT_SEL) |-> (lin_addr == 32'h0))
        else $error("selector fault with nonzero linear address");
`endif

endmodule
